### hdl/assert_macros.svh
// Assertion helpers included by the interface core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define VDPI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define VDPI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/vdpi_pkg.sv
package vdpi_pkg;

    localparam int VIDEO_MEM_DEPTH_DEF  = 16384;
    localparam int COLOUR_MEM_DEPTH_DEF = 32;
    localparam int REGISTER_COUNT_DEF   = 11;

    localparam int ADDR_W = 14;

    typedef enum logic [2:0] {
        OP_DATA_RD   = 3'd0,
        OP_DATA_WR   = 3'd1,
        OP_STATUS_RD = 3'd2,
        OP_CTRL_WR   = 3'd3,
        OP_LINE_RD   = 3'd4,
        OP_LINE_TICK = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        CODE_VRAM_RD = 2'd0,
        CODE_VRAM_WR = 2'd1,
        CODE_REG_WR  = 2'd2,
        CODE_CRAM_WR = 2'd3
    } t_access_code;

    localparam logic [7:0] STATUS_VBLANK  = 8'b1000_0000;
    localparam logic [7:0] LINE_JUMP_FROM = 8'hDA;
    localparam logic [7:0] LINE_JUMP_TO   = 8'hD5;
    localparam logic [7:0] LINE_VBLANK    = 8'hC1;
    localparam logic [7:0] LINE_LAST      = 8'hFF;
    localparam int         REG_MODE2      = 1;
    localparam int         IRQ_ENABLE_BIT = 5;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] data_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
    } t_out_item;

endpackage

### hdl/vdpi_chan_if.sv
interface vdpi_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### hdl/vdpi_ram.sv
module vdpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### hdl/video_display_port_interface_core.sv
// Channel  Direction  Payload                 Transfer when
// i_in     sink       opcode[2:0], data_in[7:0]  valid && ready
// o_out    source     read_data[7:0], irq        valid && ready
//
// One transfer per cycle unless stalled; the output register holds its result next cycle.
// A read-buffer refill from video memory lands the cycle after the access and is bypassed.
// After reset a clearing pass writes zero to all video memory entries, one per cycle,
// VIDEO_MEM_DEPTH of them (16384 by default), with i_in.ready held low.
// A stalled output holds its result and holds i_in.ready low.
module video_display_port_interface_core #(
    parameter int VIDEO_MEM_DEPTH  = vdpi_pkg::VIDEO_MEM_DEPTH_DEF,
    parameter int COLOUR_MEM_DEPTH = vdpi_pkg::COLOUR_MEM_DEPTH_DEF,
    parameter int REGISTER_COUNT   = vdpi_pkg::REGISTER_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vdpi_chan_if.sink   i_in,
    vdpi_chan_if.source o_out
);

    import vdpi_pkg::*;

    `include "assert_macros.svh"

    localparam int VAW = $clog2(VIDEO_MEM_DEPTH);
    localparam int CAW = $clog2(COLOUR_MEM_DEPTH);
    localparam int RW  = $clog2(REGISTER_COUNT);

    logic              r_clr_busy;
    logic [VAW-1:0]    r_clr_addr;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] n_addr;
    logic [1:0]        r_code;
    logic [1:0]        n_code;
    logic [7:0]        r_rb;
    logic [7:0]        n_rb;
    logic              r_rb_pend;
    logic              n_rb_pend;
    logic              r_second;
    logic              n_second;
    logic [7:0]        r_line;
    logic [7:0]        n_line;
    logic              r_vblank;
    logic              n_vblank;
    logic              r_jump;
    logic              n_jump;
    logic [7:0]        r_regs [REGISTER_COUNT];
    logic [7:0]        n_regs [REGISTER_COUNT];
    logic              r_out_valid;
    logic [7:0]        r_read_data;
    logic              r_irq;

    logic              acc;
    logic [2:0]        opcode;
    logic [7:0]        data_in;
    logic [7:0]        rb_eff;
    logic [7:0]        rd;
    logic              irq;
    logic [ADDR_W-1:0] addr_inc;
    logic [ADDR_W-1:0] ctl_addr;

    logic              vram_we;
    logic [VAW-1:0]    vram_waddr;
    logic [7:0]        vram_wdata;
    logic              vram_re;
    logic [VAW-1:0]    vram_raddr;
    logic [7:0]        vram_rdata;
    logic              cram_we;
    logic [CAW-1:0]    cram_waddr;
    logic [7:0]        cram_wdata;

    assign opcode     = i_in.payload.opcode;
    assign data_in    = i_in.payload.data_in;
    assign i_in.ready = !r_clr_busy && (!r_out_valid || o_out.ready);
    assign acc        = i_in.valid && i_in.ready;
    assign addr_inc   = r_addr + ADDR_W'(1);
    assign ctl_addr   = {data_in[ADDR_W-9:0], r_addr[7:0]};

    always_comb begin
        n_addr     = r_addr;
        n_code     = r_code;
        n_second   = r_second;
        n_line     = r_line;
        n_vblank   = r_vblank;
        n_jump     = r_jump;
        n_regs     = r_regs;
        rb_eff     = r_rb_pend ? vram_rdata : r_rb;
        n_rb       = rb_eff;
        n_rb_pend  = 1'b0;
        rd         = '0;
        vram_we    = 1'b0;
        vram_waddr = r_addr[VAW-1:0];
        vram_wdata = data_in;
        vram_re    = 1'b0;
        vram_raddr = r_addr[VAW-1:0];
        cram_we    = 1'b0;
        cram_waddr = r_addr[CAW-1:0];
        cram_wdata = data_in;
        if (r_clr_busy) begin
            vram_we    = 1'b1;
            vram_waddr = r_clr_addr;
            vram_wdata = '0;
            cram_we    = 1'b1;
            cram_waddr = r_clr_addr[CAW-1:0];
            cram_wdata = '0;
        end else if (acc) begin
            case (opcode)
                OP_DATA_RD: begin
                    n_second  = 1'b0;
                    rd        = rb_eff;
                    vram_re   = 1'b1;
                    n_rb_pend = 1'b1;
                    n_addr    = addr_inc;
                end
                OP_DATA_WR: begin
                    n_second = 1'b0;
                    if (r_code == CODE_CRAM_WR) begin
                        cram_we = 1'b1;
                    end else begin
                        vram_we = 1'b1;
                        n_rb    = data_in;
                    end
                    n_addr = addr_inc;
                end
                OP_STATUS_RD: begin
                    n_second = 1'b0;
                    rd       = r_vblank ? STATUS_VBLANK : 8'h00;
                    n_vblank = 1'b0;
                end
                OP_CTRL_WR: begin
                    if (!r_second) begin
                        n_addr   = {r_addr[ADDR_W-1:8], data_in};
                        n_second = 1'b1;
                    end else begin
                        n_second = 1'b0;
                        n_code   = data_in[7:6];
                        n_addr   = ctl_addr;
                        if (data_in[7:6] == CODE_VRAM_RD) begin
                            vram_re    = 1'b1;
                            vram_raddr = ctl_addr[VAW-1:0];
                            n_rb_pend  = 1'b1;
                            n_addr     = ctl_addr + ADDR_W'(1);
                        end else if (data_in[7:6] == CODE_REG_WR &&
                                     {1'b0, data_in[3:0]} < 5'(REGISTER_COUNT)) begin
                            n_regs[data_in[RW-1:0]] = r_addr[7:0];
                        end
                    end
                end
                OP_LINE_RD: begin
                    rd = r_line;
                end
                OP_LINE_TICK: begin
                    if (r_line == LINE_LAST) begin
                        n_line = '0;
                        n_jump = 1'b0;
                    end else if (r_line == LINE_JUMP_FROM && !r_jump) begin
                        n_line = LINE_JUMP_TO;
                        n_jump = 1'b1;
                    end else begin
                        n_line = r_line + 8'd1;
                    end
                    if (n_line == LINE_VBLANK) begin
                        n_vblank = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        irq = n_vblank && n_regs[REG_MODE2][IRQ_ENABLE_BIT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_addr      <= '0;
            r_code      <= '0;
            r_rb        <= '0;
            r_rb_pend   <= 1'b0;
            r_second    <= 1'b0;
            r_line      <= '0;
            r_vblank    <= 1'b0;
            r_jump      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < REGISTER_COUNT; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + VAW'(1);
                if (r_clr_addr == VAW'(VIDEO_MEM_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_addr    <= n_addr;
            r_code    <= n_code;
            r_rb      <= n_rb;
            r_rb_pend <= n_rb_pend;
            r_second  <= n_second;
            r_line    <= n_line;
            r_vblank  <= n_vblank;
            r_jump    <= n_jump;
            r_regs    <= n_regs;
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_read_data <= rd;
            r_irq       <= irq;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.payload.read_data = r_read_data;
    assign o_out.payload.irq       = r_irq;

    vdpi_ram #(
        .WIDTH (8),
        .DEPTH (VIDEO_MEM_DEPTH)
    ) u_video_mem (
        .i_clk   (i_clk),
        .i_we    (vram_we),
        .i_waddr (vram_waddr),
        .i_wdata (vram_wdata),
        .i_re    (vram_re),
        .i_raddr (vram_raddr),
        .o_rdata (vram_rdata)
    );

    vdpi_ram #(
        .WIDTH (8),
        .DEPTH (COLOUR_MEM_DEPTH)
    ) u_colour_mem (
        .i_clk   (i_clk),
        .i_we    (cram_we),
        .i_waddr (cram_waddr),
        .i_wdata (cram_wdata),
        .i_re    (1'b0),
        .i_raddr ('0),
        .o_rdata ()
    );

    `VDPI_ASSERT(a_clear_no_result, i_clk, i_rst_n, r_clr_busy |-> !r_out_valid, "result during clear")
    `VDPI_ASSERT(a_refill_after_transfer, i_clk, i_rst_n, r_rb_pend |-> $past(acc), "stray refill")
    `VDPI_ASSERT(a_status_clears, i_clk, i_rst_n, (acc && opcode == OP_STATUS_RD) |=> !r_vblank, "vblank kept")
    `VDPI_ASSERT(a_status_bits, i_clk, i_rst_n, (acc && opcode == OP_STATUS_RD) |=> (r_read_data[6:0] == 7'd0), "status bits")

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import vdpi_pkg::*;

    localparam int ITEM_TARGET    = 1750;
    localparam int CALM_TAIL      = 250;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 50000;

    class port_reply_board;
        logic [7:0]   vram [VIDEO_MEM_DEPTH_DEF];
        logic [7:0]   cram [COLOUR_MEM_DEPTH_DEF];
        logic [7:0]   regs [16];
        logic [13:0]  addr;
        t_access_code code;
        logic [7:0]   rbuf;
        logic [7:0]   line;
        bit           pending;
        bit           vblank;
        bit           jumped;
        t_out_item    expected_replies[$];
        int           errors;
        int           checked;
        int           ticks;
        int           wraps;
        int           irq_seen;

        function new();
            foreach (vram[i]) vram[i] = '0;
            foreach (cram[i]) cram[i] = '0;
            foreach (regs[i]) regs[i] = '0;
            addr     = '0;
            code     = CODE_VRAM_RD;
            rbuf     = '0;
            line     = '0;
            pending  = 1'b0;
            vblank   = 1'b0;
            jumped   = 1'b0;
            errors   = 0;
            checked  = 0;
            ticks    = 0;
            wraps    = 0;
            irq_seen = 0;
        endfunction

        function void note_access(t_in_item it);
            t_out_item r;
            r.read_data = '0;
            case (it.opcode)
                OP_DATA_RD: begin
                    pending = 1'b0;
                    r.read_data = rbuf;
                    rbuf = vram[addr];
                    addr++;
                end
                OP_DATA_WR: begin
                    pending = 1'b0;
                    if (code == CODE_CRAM_WR) begin
                        cram[addr[4:0]] = it.data_in;
                    end else begin
                        vram[addr] = it.data_in;
                        rbuf = it.data_in;
                    end
                    addr++;
                end
                OP_STATUS_RD: begin
                    pending = 1'b0;
                    if (vblank) r.read_data = STATUS_VBLANK;
                    vblank = 1'b0;
                end
                OP_CTRL_WR: begin
                    if (!pending) begin
                        addr[7:0] = it.data_in;
                        pending = 1'b1;
                    end else begin
                        pending = 1'b0;
                        addr[13:8] = it.data_in[5:0];
                        code = t_access_code'(it.data_in[7:6]);
                        if (code == CODE_VRAM_RD) begin
                            rbuf = vram[addr];
                            addr++;
                        end else if (code == CODE_REG_WR && it.data_in[3:0] < REGISTER_COUNT_DEF) begin
                            regs[it.data_in[3:0]] = addr[7:0];
                        end
                    end
                end
                OP_LINE_RD: begin
                    r.read_data = line;
                end
                OP_LINE_TICK: begin
                    ticks++;
                    if (line == LINE_LAST) begin
                        line = '0;
                        jumped = 1'b0;
                        wraps++;
                    end else if (line == LINE_JUMP_FROM && !jumped) begin
                        line = LINE_JUMP_TO;
                        jumped = 1'b1;
                    end else begin
                        line++;
                    end
                    if (line == LINE_VBLANK) vblank = 1'b1;
                end
                default: begin
                end
            endcase
            r.irq = vblank && regs[REG_MODE2][IRQ_ENABLE_BIT];
            expected_replies.push_back(r);
        endfunction

        function void check_reply(t_out_item got);
            t_out_item want;
            if (expected_replies.size() == 0) begin
                $display("%0t: reply with nothing expected: read_data=%h irq=%b",
                         $time, got.read_data, got.irq);
                errors++;
                return;
            end
            want = expected_replies.pop_front();
            checked++;
            if (got.irq) irq_seen++;
            if (got.read_data !== want.read_data) begin
                $display("%0t: read_data mismatch: expected %h, actual %h",
                         $time, want.read_data, got.read_data);
                errors++;
            end
            if (got.irq !== want.irq) begin
                $display("%0t: irq mismatch: expected %b, actual %b",
                         $time, want.irq, got.irq);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic long_hold;
    bit   idling;
    int   sent = 0;
    int   quiet = 0;
    port_reply_board board;

    vdpi_chan_if #(.T(t_in_item))  in_chan ();
    vdpi_chan_if #(.T(t_out_item)) out_chan ();

    video_display_port_interface_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_chan),
        .o_out   (out_chan)
    );

    always #4 i_clk = ~i_clk;

    task automatic send_access(input logic [2:0] op, input logic [7:0] d);
        t_in_item it;
        int gap;
        it.opcode  = op;
        it.data_in = d;
        if (idling && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            in_chan.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_chan.valid   <= 1'b1;
        in_chan.payload <= it;
        @(posedge i_clk);
        while (!in_chan.ready) @(posedge i_clk);
        board.note_access(it);
        sent++;
    endtask

    task automatic point_at(input t_access_code acode);
        logic [5:0] hi;
        logic [7:0] lo;
        // Mostly a small window so that reads find bytes written earlier.
        hi = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(0, 63));
        lo = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
        send_access(OP_CTRL_WR, lo);
        send_access(OP_CTRL_WR, {acode, hi});
    endtask

    initial begin
        int pick;
        logic [3:0] reg_no;
        i_rst_n         <= 1'b0;
        in_chan.valid   <= 1'b0;
        in_chan.payload <= '0;
        idling = 1'b1;
        board = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_access(OP_DATA_RD, 8'h00);
        send_access(OP_STATUS_RD, 8'h00);
        send_access(OP_LINE_RD, 8'h00);
        send_access(3'd6, 8'hFF);
        send_access(3'd7, 8'h00);
        send_access(OP_CTRL_WR, 8'h20);
        send_access(OP_CTRL_WR, {CODE_REG_WR, 2'b00, 4'(REG_MODE2)});
        // Writes at the top of video memory wrap the address to zero.
        send_access(OP_CTRL_WR, 8'hFF);
        send_access(OP_CTRL_WR, {CODE_VRAM_WR, 6'h3F});
        send_access(OP_DATA_WR, 8'hA5);
        send_access(OP_DATA_WR, 8'h5A);
        send_access(OP_CTRL_WR, 8'hFF);
        send_access(OP_CTRL_WR, {CODE_VRAM_RD, 6'h3F});
        send_access(OP_DATA_RD, 8'hFF);
        send_access(OP_DATA_RD, 8'h00);
        send_access(OP_CTRL_WR, 8'h1F);
        send_access(OP_CTRL_WR, {CODE_CRAM_WR, 6'h00});
        send_access(OP_DATA_WR, 8'hFF);
        send_access(OP_DATA_WR, 8'h00);
        send_access(OP_CTRL_WR, 8'h55);
        send_access(OP_CTRL_WR, {CODE_REG_WR, 6'h0F});
        // A tick and a line count read keep the half-written control word.
        send_access(OP_CTRL_WR, 8'h34);
        send_access(OP_LINE_TICK, 8'hFF);
        send_access(OP_LINE_RD, 8'h00);
        send_access(OP_STATUS_RD, 8'h00);
        send_access(OP_CTRL_WR, {CODE_VRAM_WR, 6'h01});

        while (sent < ITEM_TARGET) begin
            if (sent >= ITEM_TARGET - CALM_TAIL) idling = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                repeat ($urandom_range(5, 40)) send_access(OP_LINE_TICK, 8'($urandom_range(0, 255)));
            end else if (pick < 45) begin
                point_at(CODE_VRAM_WR);
                repeat ($urandom_range(1, 8)) send_access(OP_DATA_WR, 8'($urandom_range(0, 255)));
            end else if (pick < 60) begin
                point_at(CODE_VRAM_RD);
                repeat ($urandom_range(1, 8)) send_access(OP_DATA_RD, 8'($urandom_range(0, 255)));
            end else if (pick < 68) begin
                reg_no = $urandom_range(0, 1) ? 4'(REG_MODE2) : 4'($urandom_range(0, 15));
                send_access(OP_CTRL_WR, 8'($urandom_range(0, 255)));
                send_access(OP_CTRL_WR, {CODE_REG_WR, 2'($urandom_range(0, 3)), reg_no});
            end else if (pick < 75) begin
                point_at(CODE_CRAM_WR);
                repeat ($urandom_range(1, 8)) send_access(OP_DATA_WR, 8'($urandom_range(0, 255)));
            end else if (pick < 83) begin
                send_access(OP_STATUS_RD, 8'($urandom_range(0, 255)));
            end else if (pick < 89) begin
                send_access(OP_LINE_RD, 8'($urandom_range(0, 255)));
            end else begin
                send_access(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end
        end
        in_chan.valid <= 1'b0;

        while (board.expected_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d port transfers and %0d line ticks (%0d frame wraps).",
                 sent, board.ticks, board.wraps);
        $display("Checked %0d replies, %0d with the interrupt raised.",
                 board.checked, board.irq_seen);
        if (board.errors == 0 && board.expected_replies.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        int stall;
        stall = 0;
        out_chan.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_chan.valid && out_chan.ready) board.check_reply(out_chan.payload);
            if (long_hold) begin
                out_chan.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                out_chan.ready <= 1'b0;
            end else if (idling && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 6) - 1;
                out_chan.ready <= 1'b0;
            end else begin
                out_chan.ready <= 1'b1;
            end
        end
    end

    // The receiver stops for a long stretch so the block fills and stalls its input.
    initial begin
        long_hold <= 1'b0;
        wait (sent >= 400);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end
endmodule
